FILE: rtl/urd_pkg.sv
// Shared widths, command and status types for the unsigned restoring divider.
`default_nettype none

package urd_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DATA_WIDTH - 1);

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } t_urd_cmd;

    typedef struct packed {
        logic last;
    } t_urd_sts;

endpackage

`default_nettype wire

FILE: rtl/urd_if.sv
// Valid/ready channel interfaces for divider operands and results.
`default_nettype none

interface urd_in_if import urd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word dividend;
    t_word divisor_in;

    modport source (output valid, output dividend, output divisor_in, input ready);
    modport sink   (input valid, input dividend, input divisor_in, output ready);
endinterface

interface urd_out_if import urd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word quotient;
    t_word remainder;
    logic  div_by_zero;

    modport source (output valid, output quotient, output remainder, output div_by_zero,
                    input ready);
    modport sink   (input valid, input quotient, input remainder, input div_by_zero,
                     output ready);
endinterface

`default_nettype wire

FILE: rtl/urd_dp.sv
// Divider datapath: partial remainder, quotient shifter, step counter, result register.
`default_nettype none

module urd_dp import urd_pkg::*; (
    input  wire logic     i_clk,
    input  wire t_urd_cmd i_cmd,
    input  wire t_word    i_dividend,
    input  wire t_word    i_divisor,
    output t_urd_sts      o_sts,
    output t_word         o_quotient,
    output t_word         o_remainder,
    output logic          o_div_by_zero
);

    t_word                 r_rem, n_rem;
    t_word                 r_quo, n_quo;
    t_word                 r_den;
    logic                  r_dbz;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    t_word                 r_out_quo;
    t_word                 r_out_rem;
    logic                  r_out_dbz;

    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;

    always_comb begin
        trial = {r_rem, r_quo[DATA_WIDTH-1]};
        diff  = trial - {1'b0, r_den};
        n_cnt = r_cnt - CNT_W'(1);
        if (diff[DATA_WIDTH]) begin
            n_rem = trial[DATA_WIDTH-1:0];
            n_quo = {r_quo[DATA_WIDTH-2:0], 1'b0};
        end else begin
            n_rem = diff[DATA_WIDTH-1:0];
            n_quo = {r_quo[DATA_WIDTH-2:0], 1'b1};
        end
    end

    assign o_sts.last = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
            r_dbz <= (i_divisor == '0);
            r_cnt <= LAST_CNT;
        end else if (i_cmd.step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= n_cnt;
        end
        if (i_cmd.publish) begin
            r_out_quo <= i_cmd.step ? n_quo : r_quo;
            r_out_rem <= i_cmd.step ? n_rem : r_rem;
            r_out_dbz <= r_dbz;
        end
    end

    assign o_quotient    = r_out_quo;
    assign o_remainder   = r_out_rem;
    assign o_div_by_zero = r_out_dbz;

endmodule

`default_nettype wire

FILE: rtl/urd_ctrl.sv
// Divider controller: sequences load, step and publish, owns the result-valid flag.
`default_nettype none

module urd_ctrl import urd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_urd_sts i_sts,
    output t_urd_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.step    = 1'b0;
        o_cmd.publish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    if (out_free) begin
                        o_cmd.publish = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: rtl/unsigned_restoring_divider.sv
// Top level of the unsigned restoring divider: controller plus datapath.
//
//  channel  | dir | beat payload                            | handshake
//  ---------+-----+-----------------------------------------+------------
//  i_req    | in  | dividend, divisor_in                    | valid/ready
//  o_rsp    | out | quotient, remainder, div_by_zero        | valid/ready
//
// A beat is loaded first, then resolved one quotient bit per cycle
// through the single subtract-and-restore stage, 32 steps.
// Synchronous active-low reset clears the controller and the result-valid flag.
// A finished result sits in its own register; a new beat is taken while it waits.
// If that register is still full when the last step ends, hold until it drains.
// Zero divisor: quotient all ones, remainder equals dividend, div_by_zero set.
`default_nettype none

module unsigned_restoring_divider import urd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    urd_in_if.sink    i_req,
    urd_out_if.source o_rsp
);

    t_urd_cmd cmd;
    t_urd_sts sts;

    urd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    urd_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_dividend    (i_req.dividend),
        .i_divisor     (i_req.divisor_in),
        .o_sts         (sts),
        .o_quotient    (o_rsp.quotient),
        .o_remainder   (o_rsp.remainder),
        .o_div_by_zero (o_rsp.div_by_zero)
    );

endmodule

`default_nettype wire

FILE: tb/unsigned_restoring_divider_test.sv
// Self-checking testbench for the unsigned restoring divider with random flow control.
module unsigned_restoring_divider_test import urd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_TICKS = 40;

    typedef struct packed {
        t_word quotient;
        t_word remainder;
        logic  div_by_zero;
    } t_div_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    urd_in_if  req_if ();
    urd_out_if rsp_if ();

    t_div_result owed_results[$];
    int          fault_count  = 0;
    int          quiet_cycles = 0;
    bit          sender_idles    = 1'b1;
    bit          receiver_stalls = 1'b1;
    bit          hold_results    = 1'b0;

    unsigned_restoring_divider dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_div_result restoring_divide(t_word num, t_word den);
        t_div_result res;
        t_word       shifted;
        res.div_by_zero = (den == '0);
        res.quotient    = '1;
        res.remainder   = num;
        if (!res.div_by_zero) begin
            res.quotient = '0;
            for (int pos = DATA_WIDTH - 1; pos >= 0; pos--) begin
                shifted = den << pos;
                if ((shifted >> pos) == den && res.remainder >= shifted) begin
                    res.remainder     = res.remainder - shifted;
                    res.quotient[pos] = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic t_word random_operand();
        int bits;
        bits = $urandom_range(0, DATA_WIDTH);
        if (bits == 0) return '0;
        return t_word'($urandom()) >> (DATA_WIDTH - bits);
    endfunction

    task automatic send_operands(input t_word num, input t_word den);
        int gap;
        gap = sender_idles ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.dividend   <= num;
        req_if.divisor_in <= den;
        do @(posedge i_clk); while (!req_if.ready);
        owed_results.push_back(restoring_divide(num, den));
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed_cases();
        t_word nums[$];
        t_word dens[$];
        nums = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                 32'h1234_5678, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'h0000_0007};
        dens = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0002,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000, 32'h0000_0007, 32'hC000_0001};
        foreach (nums[k]) send_operands(nums[k], dens[k]);
    endtask

    task automatic run_output_backpressure();
        sender_idles = 1'b0;
        hold_results = 1'b1;
        repeat (12) send_operands(random_operand(), random_operand());
        sender_idles = 1'b1;
    endtask

    task automatic run_drain_pause();
        repeat (20) send_operands(random_operand(), random_operand());
        drain_results();
    endtask

    task automatic run_random_traffic();
        t_word num;
        t_word den;
        for (int seg = 0; seg < 14; seg++) begin
            sender_idles    = $urandom_range(0, 1);
            receiver_stalls = $urandom_range(0, 1);
            repeat (50) begin
                den = random_operand();
                case ($urandom_range(0, 9))
                    0: begin
                        den = '0;
                        num = random_operand();
                    end
                    1: num = den * t_word'($urandom_range(0, 5000));
                    2: num = t_word'($urandom());
                    default: num = random_operand();
                endcase
                send_operands(num, den);
            end
        end
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    initial begin
        rsp_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            int stall;
            if (hold_results) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end
            stall = receiver_stalls ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_if.valid || hold_results));
        end
    end

    always @(posedge i_clk) begin
        t_div_result got;
        t_div_result want;
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got = '{rsp_if.quotient, rsp_if.remainder, rsp_if.div_by_zero};
            if (owed_results.size() == 0) begin
                if (fault_count < 10)
                    $display("unexpected result beat: q=%h r=%h z=%b",
                             got.quotient, got.remainder, got.div_by_zero);
                fault_count++;
            end else begin
                want = owed_results.pop_front();
                if (got.quotient !== want.quotient || got.remainder !== want.remainder ||
                    got.div_by_zero !== want.div_by_zero) begin
                    if (fault_count < 10)
                        $display("mismatch: q=%h/%h r=%h/%h z=%b/%b (expected/actual)",
                                 want.quotient, got.quotient, want.remainder,
                                 got.remainder, want.div_by_zero, got.div_by_zero);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.dividend   <= '0;
        req_if.divisor_in <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed_cases();
        run_output_backpressure();
        run_drain_pause();
        run_random_traffic();

        drain_results();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (fault_count == 0 && owed_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
